### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, reset disables every check
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define WSFP_ASSERT_NOW(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("wsfp assertion failed");

// consequent holds in the same cycle as the antecedent
`define WSFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsfp assertion failed");

// consequent holds in the cycle after the antecedent
`define WSFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsfp assertion failed");

`endif

### rtl/wsfp_pkg.sv
// ----------------------------------------------------------------------------
// wsfp_pkg
// types and constants shared by the websocket frame header parser
// ----------------------------------------------------------------------------
package wsfp_pkg;

    localparam int LEN_W  = 63;
    localparam int ACC_W  = 64;
    localparam int BYTE_W = 8;

    localparam logic [3:0] HDR_BASE       = 4'd2;
    localparam logic [3:0] HDR_MASKED     = 4'd6;
    localparam logic [3:0] HDR_EXT16      = 4'd8;
    localparam logic [3:0] HDR_EXT64      = 4'd14;
    localparam logic [3:0] MASK_KEY_BYTES = 4'd4;

    localparam logic [6:0] CODE_EXT16 = 7'd126;
    localparam logic [6:0] CODE_EXT64 = 7'd127;

    localparam logic [3:0] POS_FIRST  = 4'd0;
    localparam logic [3:0] POS_SECOND = 4'd1;
    localparam logic [3:0] POS_EXT    = 4'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_PARTIAL = 2'd0,
        ST_READY   = 2'd1,
        ST_ERROR   = 2'd2
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] byte_out;
        logic              is_payload;
        logic              fin_flag;
        logic [3:0]        opcode;
        logic [3:0]        header_size;
        logic [LEN_W-1:0]  payload_length;
    } t_result;

endpackage

### rtl/wsfp_in_if.sv
// ----------------------------------------------------------------------------
// wsfp_in_if
// received byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface wsfp_in_if;
    import wsfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

### rtl/wsfp_out_if.sv
// ----------------------------------------------------------------------------
// wsfp_out_if
// per-byte parse result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface wsfp_out_if;
    import wsfp_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [BYTE_W-1:0] byte_out;
    logic              is_payload;
    logic              fin_flag;
    logic [3:0]        opcode;
    logic [3:0]        header_size;
    logic [LEN_W-1:0]  payload_length;

    modport source (
        output valid, output status, output byte_out, output is_payload,
        output fin_flag, output opcode, output header_size, output payload_length,
        input ready
    );
    modport sink (
        input valid, input status, input byte_out, input is_payload,
        input fin_flag, input opcode, input header_size, input payload_length,
        output ready
    );
endinterface

### rtl/wsfp_front.sv
// ----------------------------------------------------------------------------
// wsfp_front
// frame header state machine: classifies each byte and builds its result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsfp_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wsfp_pkg::LEN_W-1:0]  i_cfg_wdata,
    wsfp_in_if.sink                     i_in,
    input  logic                        i_q_ready,
    output logic                        o_push,
    output wsfp_pkg::t_result           o_result
);
    import wsfp_pkg::*;

    typedef enum logic [2:0] {
        PH_BASE    = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    t_phase             r_phase,   n_phase;
    logic [3:0]         r_pos,     n_pos;
    logic [BYTE_W-1:0]  r_hdr0,    n_hdr0;
    logic [3:0]         r_hs,      n_hs;
    logic [ACC_W-1:0]   r_acc,     n_acc;
    logic [LEN_W-1:0]   r_remain,  n_remain;
    logic [LEN_W-1:0]   r_max_len;

    logic               w_accept;
    logic [BYTE_W-1:0]  w_byte;
    logic [6:0]         w_code;
    logic [3:0]         w_hs_new;
    logic [ACC_W-1:0]   w_acc_new;
    logic               w_ext;
    logic               w_last;
    logic [ACC_W-1:0]   w_acc_sh;
    logic               w_over;

    assign w_accept    = i_in.valid && i_q_ready;
    assign i_in.ready  = i_q_ready;
    assign o_push      = w_accept;
    assign w_byte      = i_in.byte_in;
    assign w_code      = w_byte[6:0];

    assign w_hs_new  = (w_code == CODE_EXT16) ? HDR_EXT16 :
                       (w_code == CODE_EXT64) ? HDR_EXT64 : HDR_MASKED;
    assign w_acc_new = (w_code < CODE_EXT16) ? {{(ACC_W-7){1'b0}}, w_code} : '0;

    // extended length bytes sit between the base header and the mask key
    assign w_ext    = r_pos < (r_hs - MASK_KEY_BYTES);
    assign w_acc_sh = w_ext ? {r_acc[ACC_W-BYTE_W-1:0], w_byte} : r_acc;
    assign w_last   = (r_pos == (r_hs - 4'd1));
    assign w_over   = w_acc_sh > {1'b0, r_max_len};

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_hdr0   = r_hdr0;
        n_hs     = r_hs;
        n_acc    = r_acc;
        n_remain = r_remain;

        o_result.status         = ST_PARTIAL;
        o_result.byte_out       = w_byte;
        o_result.is_payload     = 1'b0;
        o_result.fin_flag       = r_hdr0[7];
        o_result.opcode         = r_hdr0[3:0];
        o_result.header_size    = HDR_BASE;
        o_result.payload_length = '0;

        case (r_phase)
            PH_HEADER: begin
                o_result.header_size = r_hs;
                n_acc = w_acc_sh;
                if (r_hs == HDR_MASKED || w_last) begin
                    o_result.payload_length = w_acc_sh[LEN_W-1:0];
                end
                if (w_last) begin
                    if (w_over) begin
                        o_result.status = ST_ERROR;
                        n_phase = PH_BASE;
                        n_pos   = POS_FIRST;
                    end else if (w_acc_sh == '0) begin
                        o_result.status = ST_READY;
                        n_phase = PH_BASE;
                        n_pos   = POS_FIRST;
                    end else begin
                        n_phase  = PH_PAYLOAD;
                        n_remain = w_acc_sh[LEN_W-1:0];
                    end
                end else begin
                    n_pos = r_pos + 4'd1;
                end
            end
            PH_PAYLOAD: begin
                o_result.is_payload     = 1'b1;
                o_result.header_size    = r_hs;
                o_result.payload_length = r_acc[LEN_W-1:0];
                if (r_remain == {{(LEN_W-1){1'b0}}, 1'b1}) begin
                    o_result.status = ST_READY;
                    n_phase = PH_BASE;
                    n_pos   = POS_FIRST;
                end else begin
                    n_remain = r_remain - {{(LEN_W-1){1'b0}}, 1'b1};
                end
            end
            default: begin
                if (r_pos == POS_FIRST) begin
                    n_hdr0 = w_byte;
                    o_result.fin_flag = w_byte[7];
                    o_result.opcode   = w_byte[3:0];
                    n_pos = POS_SECOND;
                end else if (!w_byte[7]) begin
                    // unmasked frame from a client
                    o_result.status = ST_ERROR;
                    n_phase = PH_BASE;
                    n_pos   = POS_FIRST;
                end else begin
                    n_hs  = w_hs_new;
                    n_acc = w_acc_new;
                    o_result.header_size    = w_hs_new;
                    o_result.payload_length = w_acc_new[LEN_W-1:0];
                    n_pos   = POS_EXT;
                    n_phase = PH_HEADER;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_BASE;
            r_pos     <= POS_FIRST;
            r_max_len <= '1;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hdr0   <= n_hdr0;
            r_hs     <= n_hs;
            r_acc    <= n_acc;
            r_remain <= n_remain;
        end
    end

    `WSFP_ASSERT_IMP(a_payload_left, i_clk, i_rst_n, r_phase == PH_PAYLOAD, r_remain != '0)
    `WSFP_ASSERT_IMP(a_header_pos, i_clk, i_rst_n, r_phase == PH_HEADER, (r_pos >= POS_EXT) && (r_pos < r_hs))

endmodule

### rtl/wsfp_queue.sv
// ----------------------------------------------------------------------------
// wsfp_queue
// short result queue between the parser and the output stage
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsfp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  wsfp_pkg::t_result  i_data,
    output logic               o_ready,
    output logic               o_valid,
    output wsfp_pkg::t_result  o_data,
    input  logic               i_pop
);
    import wsfp_pkg::*;

    t_result                r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count,  n_count;
    logic                   w_push;
    logic                   w_pop;

    localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

    assign o_ready = r_count != CNT_FULL;
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `WSFP_ASSERT_NOW(a_count_range, i_clk, i_rst_n, r_count <= CNT_FULL)
    `WSFP_ASSERT_NXT(a_count_grow, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 1'b1)

endmodule

### rtl/wsfp_back.sv
// ----------------------------------------------------------------------------
// wsfp_back
// output register: drains the queue into the result channel
// ----------------------------------------------------------------------------
module wsfp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  wsfp_pkg::t_result  i_q_data,
    output logic               o_pop,
    wsfp_out_if.source         o_out
);
    import wsfp_pkg::*;

    logic    r_valid;
    t_result r_data;

    // refill whenever the held request is gone or leaves this cycle
    assign o_pop = i_q_valid && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || o_out.ready) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_q_data;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.status         = r_data.status;
    assign o_out.byte_out       = r_data.byte_out;
    assign o_out.is_payload     = r_data.is_payload;
    assign o_out.fin_flag       = r_data.fin_flag;
    assign o_out.opcode         = r_data.opcode;
    assign o_out.header_size    = r_data.header_size;
    assign o_out.payload_length = r_data.payload_length;

endmodule

### rtl/websocket_frame_header_parser_core.sv
// ----------------------------------------------------------------------------
// websocket_frame_header_parser_core
// delimits websocket frames in a received byte stream, one result per byte
// ----------------------------------------------------------------------------
// Takes one byte per clock and returns one result per byte in the same order:
// the byte unchanged, whether it is header or payload, the header fields seen
// so far and a status (incomplete, frame ready, error). A request is taken
// in any cycle in which the four-entry result queue has room, so with the
// output side ready the block sustains one byte per cycle; that figure is set
// by the parser state machine, which updates its length and position state
// for each byte as it is taken. A result reaches the output through the queue
// and the output register. Unmasked frames and lengths above the limit
// register end in error status, after which parsing restarts at a new header.
// The limit register may be written only while no result is outstanding.
// ----------------------------------------------------------------------------
module websocket_frame_header_parser_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wsfp_pkg::LEN_W-1:0]  i_cfg_wdata,
    wsfp_in_if.sink                     i_in,
    wsfp_out_if.source                  o_out
);
    import wsfp_pkg::*;

    logic    w_push;
    t_result w_push_data;
    logic    w_q_ready;
    logic    w_q_valid;
    t_result w_q_data;
    logic    w_pop;

    wsfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_q_ready   (w_q_ready),
        .o_push      (w_push),
        .o_result    (w_push_data)
    );

    wsfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_pop)
    );

    wsfp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// byte-stream checker for the websocket frame header parser core
// ----------------------------------------------------------------------------
// Feeds the parser a stream of websocket frames. The stream starts with a
// short hand-built set: a zero-length frame, an unmasked frame, a one-byte
// payload and a 64-bit length that is over the limit. Random frames follow,
// mostly well formed and with some junk bytes mixed in, over several settings
// of the length limit. A local model of the parser predicts the result for
// every accepted byte, and each result is compared field by field in order.
// The sender works in bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb;
    import wsfp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_BYTES    = 140;
    localparam int NUM_PHASES     = 7;

    typedef enum logic [1:0] {
        PH_BASE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_parse_phase;

    typedef enum int {
        SZ_SHORT,
        SZ_EXT16,
        SZ_EXT64
    } t_len_form;

    typedef enum int {
        RX_OPEN,
        RX_THREE_IN_FOUR,
        RX_COIN,
        RX_SPARSE
    } t_rx_mode;

    class frame_scoreboard;
        t_result          expected_q[$];
        int unsigned      errors;
        logic [LEN_W-1:0] max_len;
        t_parse_phase     phase;
        logic [63:0]      pos;
        logic [7:0]       hdr0;
        logic [6:0]       code;
        logic [3:0]       hsize;
        logic [63:0]      acc;
        logic [63:0]      end_pos;

        function new();
            errors  = 0;
            max_len = '1;
            restart();
        endfunction

        function void restart();
            phase   = PH_BASE;
            pos     = '0;
            hdr0    = '0;
            code    = '0;
            hsize   = HDR_BASE;
            acc     = '0;
            end_pos = 64'(HDR_BASE);
        endfunction

        function void set_limit(logic [LEN_W-1:0] v);
            max_len = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // work out the result of one accepted byte and advance the frame state
        function void note_byte(logic [7:0] b);
            t_result     want;
            logic [63:0] ext_end;
            bit          last;
            bit          done;
            want.status         = ST_PARTIAL;
            want.byte_out       = b;
            want.is_payload     = 1'b0;
            want.fin_flag       = hdr0[7];
            want.opcode         = hdr0[3:0];
            want.header_size    = HDR_BASE;
            want.payload_length = '0;
            done = 1'b0;
            case (phase)
                PH_HEADER: begin
                    ext_end = 64'(HDR_BASE) + 64'(hsize) - 64'(HDR_MASKED);
                    last = (pos + 64'd1 >= 64'(hsize));
                    want.header_size = hsize;
                    if (pos < ext_end) begin
                        acc = {acc[55:0], b};
                    end
                    // an extended length shows only once it is complete
                    if (code < CODE_EXT16 || last) begin
                        want.payload_length = acc[LEN_W-1:0];
                    end
                    if (last) begin
                        if (acc > {1'b0, max_len}) begin
                            want.status = ST_ERROR;
                            done = 1'b1;
                        end else if (acc == '0) begin
                            want.status = ST_READY;
                            done = 1'b1;
                        end else begin
                            end_pos = 64'(hsize) + acc;
                            phase = PH_PAYLOAD;
                            pos = pos + 64'd1;
                        end
                    end else begin
                        pos = pos + 64'd1;
                    end
                end
                PH_PAYLOAD: begin
                    want.is_payload     = 1'b1;
                    want.header_size    = hsize;
                    want.payload_length = acc[LEN_W-1:0];
                    if (pos + 64'd1 >= end_pos) begin
                        want.status = ST_READY;
                        done = 1'b1;
                    end else begin
                        pos = pos + 64'd1;
                    end
                end
                default: begin
                    if (pos == '0) begin
                        phase         = PH_BASE;
                        hdr0          = b;
                        want.fin_flag = b[7];
                        want.opcode   = b[3:0];
                        pos           = 64'd1;
                    end else if (!b[7]) begin
                        // mask bit clear
                        want.status = ST_ERROR;
                        done = 1'b1;
                    end else begin
                        code  = b[6:0];
                        hsize = (code == CODE_EXT16) ? HDR_EXT16 :
                                (code == CODE_EXT64) ? HDR_EXT64 : HDR_MASKED;
                        acc   = (code < CODE_EXT16) ? {57'd0, code} : '0;
                        want.header_size    = hsize;
                        want.payload_length = acc[LEN_W-1:0];
                        pos   = 64'd2;
                        phase = PH_HEADER;
                    end
                end
            endcase
            expected_q.push_back(want);
            if (done) begin
                restart();
            end
        endfunction

        function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $error("result with no byte outstanding: byte_out %0h", got.byte_out);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            cmp_field("status", 64'(want.status), 64'(got.status));
            cmp_field("byte_out", 64'(want.byte_out), 64'(got.byte_out));
            cmp_field("is_payload", 64'(want.is_payload), 64'(got.is_payload));
            cmp_field("fin_flag", 64'(want.fin_flag), 64'(got.fin_flag));
            cmp_field("opcode", 64'(want.opcode), 64'(got.opcode));
            cmp_field("header_size", 64'(want.header_size), 64'(got.header_size));
            cmp_field("payload_length", 64'(want.payload_length),
                      64'(got.payload_length));
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [LEN_W-1:0] i_cfg_wdata;

    wsfp_in_if  in_ch ();
    wsfp_out_if out_ch ();

    websocket_frame_header_parser_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    frame_scoreboard sb;
    logic [7:0]      tx_bytes[$];
    int              burst_left;
    int              idle_cycles;
    t_rx_mode        rx_mode;
    int              rx_left;
    int unsigned     rx_tick;
    t_result         seen;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver stall pattern, switching to a randomly chosen mode after each run
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:          out_ch.ready <= 1'b1;
            RX_THREE_IN_FOUR: out_ch.ready <= (rx_tick[1:0] != 2'd0);
            RX_COIN:          out_ch.ready <= 1'($urandom_range(0, 1));
            default:          out_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
        rx_tick++;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                sb.note_byte(in_ch.byte_in);
            end
            if (out_ch.valid && out_ch.ready) begin
                seen.status         = t_status'(out_ch.status);
                seen.byte_out       = out_ch.byte_out;
                seen.is_payload     = out_ch.is_payload;
                seen.fin_flag       = out_ch.fin_flag;
                seen.opcode         = out_ch.opcode;
                seen.header_size    = out_ch.header_size;
                seen.payload_length = out_ch.payload_length;
                sb.check_result(seen);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // checked on the falling edge so the count is settled for this cycle
    task wait_drained();
        do @(negedge i_clk); while (sb.pending() != 0);
        @(posedge i_clk);
    endtask

    task write_limit(input logic [LEN_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_limit(v);
    endtask

    // header; for masked frames also mask key and any payload the parser takes
    task add_frame(input logic [7:0] b0, input bit masked, input t_len_form form,
                   input logic [63:0] len);
        tx_bytes.push_back(b0);
        if (!masked) begin
            tx_bytes.push_back({1'b0, 7'($urandom)});
            return;
        end
        // keep accepted payloads short, long lengths only where they fail
        if (len > 64'd300 && len <= {1'b0, sb.max_len}) begin
            if (form == SZ_EXT64) begin
                len[63] = 1'b1;
            end else begin
                len = len % 16;
            end
        end
        case (form)
            SZ_SHORT: tx_bytes.push_back({1'b1, len[6:0]});
            SZ_EXT16: begin
                tx_bytes.push_back({1'b1, CODE_EXT16});
                tx_bytes.push_back(len[15:8]);
                tx_bytes.push_back(len[7:0]);
            end
            default: begin
                tx_bytes.push_back({1'b1, CODE_EXT64});
                for (int i = 7; i >= 0; i--) begin
                    tx_bytes.push_back(len[8*i +: 8]);
                end
            end
        endcase
        repeat (int'(MASK_KEY_BYTES)) tx_bytes.push_back(8'($urandom));
        if (len != '0 && len <= {1'b0, sb.max_len}) begin
            repeat (int'(len[15:0])) tx_bytes.push_back(8'($urandom));
        end
    endtask

    task build_random_frames(input int target);
        int          r;
        logic [63:0] len;
        while (tx_bytes.size() < target) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                len = ($urandom_range(0, 9) < 7) ? 64'($urandom_range(0, 12)) :
                      64'($urandom_range(0, 125));
                add_frame(8'($urandom), 1'b1, SZ_SHORT, len);
            end else if (r < 65) begin
                len = ($urandom_range(0, 9) < 6) ? 64'($urandom_range(0, 20)) :
                      64'($urandom_range(0, 65535));
                add_frame(8'($urandom), 1'b1, SZ_EXT16, len);
            end else if (r < 75) begin
                len = $urandom_range(0, 1) ? 64'($urandom_range(0, 20)) :
                      {$urandom, $urandom};
                add_frame(8'($urandom), 1'b1, SZ_EXT64, len);
            end else if (r < 88 || sb.max_len > 300) begin
                add_frame(8'($urandom), 1'b0, SZ_SHORT, '0);
            end else begin
                // junk that knocks the parser off frame boundaries
                repeat ($urandom_range(1, 5)) tx_bytes.push_back(8'($urandom));
            end
        end
    endtask

    task send_stream();
        bit pause;
        int gap;
        for (int i = 0; i < tx_bytes.size(); i++) begin
            pause = ($urandom_range(0, 249) == 0);
            gap = 0;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (pause || gap > 0) begin
                in_ch.valid <= 1'b0;
                if (pause) begin
                    wait_drained();
                end
                repeat (gap) @(posedge i_clk);
            end
            in_ch.valid   <= 1'b1;
            in_ch.byte_in <= tx_bytes[i];
            do @(posedge i_clk); while (!in_ch.ready);
            burst_left--;
        end
        in_ch.valid <= 1'b0;
        tx_bytes.delete();
    endtask

    initial begin
        logic [LEN_W-1:0] limits[NUM_PHASES];
        sb            = new();
        burst_left    = 0;
        idle_cycles   = 0;
        rx_left       = 0;
        rx_tick       = 0;
        rx_mode       = RX_OPEN;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        in_ch.valid   = 1'b0;
        in_ch.byte_in = '0;
        out_ch.ready  = 1'b0;

        limits[0] = '1;
        limits[1] = '0;
        limits[2] = LEN_W'(1);
        limits[3] = LEN_W'($urandom_range(2, 300));
        limits[4] = '1;
        limits[5] = LEN_W'($urandom_range(20, 120));
        limits[6] = LEN_W'({$urandom, $urandom});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero length with reserved bits set, unmasked, one payload byte,
        // then an all-ones 64-bit length
        add_frame(8'hF0, 1'b1, SZ_SHORT, 64'd0);
        add_frame(8'h0F, 1'b0, SZ_SHORT, 64'd0);
        add_frame(8'h81, 1'b1, SZ_SHORT, 64'd1);
        add_frame(8'h89, 1'b1, SZ_EXT64, '1);
        send_stream();
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                write_limit(limits[p]);
            end
            build_random_frames(PHASE_BYTES);
            send_stream();
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/wsfp_pkg.sv
rtl/wsfp_in_if.sv
rtl/wsfp_out_if.sv
rtl/wsfp_front.sv
rtl/wsfp_queue.sv
rtl/wsfp_back.sv
rtl/websocket_frame_header_parser_core.sv
sim/tb.sv
